/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the switch cost planner.
// Self-contained; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/tssc_pkg.sv */
// Package of the switch cost planner: widths, sequencer states and the
// operand and result types of the shared cost unit. Depends on nothing.
package tssc_pkg;

   localparam int MAX_PERIODS_DEF = 64;
   localparam int COST_W          = 16;
   localparam int BEST_W          = 23;
   localparam int SUM_W           = BEST_W + 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VB,
      ST_VA,
      ST_SA,
      ST_SB,
      ST_FIN,
      ST_TB_RD,
      ST_TB_WR,
      ST_EM_RD,
      ST_EM_LD,
      ST_EM_WAIT
   } state_type;

   typedef struct packed {
      logic [BEST_W-1:0] x;
      logic [COST_W-1:0] y;
      logic [BEST_W-1:0] z;
   } alu_op_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             lt;
   } alu_res_type;

endpackage

/* rtl/two_state_switch_cost_plan.sv */
// Two-site minimum-cost planner with traceback. Each req_ transaction carries
// one period's operating cost at site A and at site B; the block keeps the
// least total cost of a plan ending at each site, where staying is free and
// moving costs csr_switch_cost (a tie picks the move). The first period of a
// plan is loaded as it is accepted; every later period is accepted and then
// takes four steps of the one shared adder/comparator, during which req_ready
// is low. A plan closes on a transaction with req_final_period set, or when
// MAX_PERIODS periods are held. Closing picks the final site (a tie picks B),
// traces back one period at a time through the backpointer memory in a read
// step and a write step, then gives each rsp_ transaction in a read, a load
// and a wait step, the wait holding while rsp_ready is low; the read steps
// follow from the registered memory reads. Results come in forward period
// order, the last one with rsp_plan_end set. csr_ writes are taken at once.
// Depends on tssc_pkg, tssc_alu, tssc_ram and assert_macros.svh.
`include "assert_macros.svh"

module two_state_switch_cost_plan #(
   parameter int MAX_PERIODS = tssc_pkg::MAX_PERIODS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // input channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tssc_pkg::COST_W-1:0] req_cost_site_a,
   input  logic [tssc_pkg::COST_W-1:0] req_cost_site_b,
   input  logic                        req_final_period,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_site,
   output logic                        rsp_plan_end,
   // configuration write channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tssc_pkg::COST_W-1:0] csr_switch_cost
);
   import tssc_pkg::*;

   localparam int AW = $clog2(MAX_PERIODS);
   localparam int CW = $clog2(MAX_PERIODS + 1);

   // Sequencer and plan bookkeeping
   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic              cur_ff, cur_in;

   // Running costs and per-period working values
   logic [COST_W-1:0] sw_ff, sw_in;
   logic [BEST_W-1:0] best_a_ff, best_a_in;
   logic [BEST_W-1:0] best_b_ff, best_b_in;
   logic [BEST_W-1:0] na_ff, na_in;
   logic [BEST_W-1:0] nb_ff, nb_in;
   logic [1:0]        bits_ff, bits_in;
   logic [COST_W-1:0] ca_ff, ca_in;
   logic [COST_W-1:0] cb_ff, cb_in;
   logic              last_ff, last_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_site_ff, rsp_site_in;
   logic              rsp_end_ff, rsp_end_in;

   // Shared unit and memories
   alu_op_type        alu_op;
   alu_res_type       alu_res;
   logic              back_we, back_re;
   logic [1:0]        back_wd, back_rd;
   logic              plan_we, plan_re;
   logic [AW-1:0]     plan_wa;
   logic              plan_wd, plan_rd;

   logic [CW-1:0]     count_m1;
   logic [AW-1:0]     last_idx;
   logic              at_limit;

   assign count_m1 = count_ff - CW'(1);
   assign last_idx = count_m1[AW-1:0];
   // Store is full once this period is counted
   assign at_limit = (count_ff + CW'(1)) == CW'(MAX_PERIODS);

   tssc_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   // Backpointer store: bit 0 is the site before when now at A,
   // bit 1 the site before when now at B.
   tssc_ram #(
      .WIDTH (2),
      .DEPTH (MAX_PERIODS)
   ) u_back_ram (
      .clock   (clock),
      .wr_en   (back_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (back_wd),
      .rd_en   (back_re),
      .rd_addr (ptr_ff),
      .rd_data (back_rd)
   );

   // Traced sites of the closing plan, read back in forward order
   tssc_ram #(
      .WIDTH (1),
      .DEPTH (MAX_PERIODS)
   ) u_plan_ram (
      .clock   (clock),
      .wr_en   (plan_we),
      .wr_addr (plan_wa),
      .wr_data (plan_wd),
      .rd_en   (plan_re),
      .rd_addr (ptr_ff),
      .rd_data (plan_rd)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (count_ff == '0) begin
                  state_in = (req_final_period || at_limit) ? ST_FIN : ST_IDLE;
               end else begin
                  state_in = ST_VB;
               end
            end
         end
         ST_VB:    state_in = ST_VA;
         ST_VA:    state_in = ST_SA;
         ST_SA:    state_in = ST_SB;
         ST_SB:    state_in = (last_ff || at_limit) ? ST_FIN : ST_IDLE;
         ST_FIN:   state_in = (last_idx == '0) ? ST_EM_RD : ST_TB_RD;
         ST_TB_RD: state_in = ST_TB_WR;
         ST_TB_WR: state_in = (ptr_ff == AW'(1)) ? ST_EM_RD : ST_TB_RD;
         ST_EM_RD: state_in = ST_EM_LD;
         ST_EM_LD: state_in = ST_EM_WAIT;
         ST_EM_WAIT: begin
            if (rsp_ready) begin
               state_in = rsp_end_ff ? ST_IDLE : ST_EM_RD;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory controls and outputs
   always_comb begin
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      cur_in       = cur_ff;
      best_a_in    = best_a_ff;
      best_b_in    = best_b_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      bits_in      = bits_ff;
      ca_in        = ca_ff;
      cb_in        = cb_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_site_in  = rsp_site_ff;
      rsp_end_in   = rsp_end_ff;
      alu_op       = '0;
      back_we      = 1'b0;
      back_wd      = bits_ff;
      back_re      = 1'b0;
      plan_we      = 1'b0;
      plan_wa      = last_idx;
      plan_wd      = cur_ff;
      plan_re      = 1'b0;

      sw_in = csr_valid ? csr_switch_cost : sw_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ca_in   = req_cost_site_a;
               cb_in   = req_cost_site_b;
               last_in = req_final_period;
               // First period: load the costs, backpointers are never read
               if (count_ff == '0) begin
                  best_a_in = BEST_W'(req_cost_site_a);
                  best_b_in = BEST_W'(req_cost_site_b);
                  back_we   = 1'b1;
                  back_wd   = '0;
                  count_in  = count_ff + CW'(1);
               end
            end
         end
         ST_VB: begin
            // Reach A: stay at A, or move from B (tie picks the move)
            alu_op     = '{x: best_b_ff, y: sw_ff, z: best_a_ff};
            na_in      = alu_res.lt ? best_a_ff : alu_res.sum[BEST_W-1:0];
            bits_in[0] = ~alu_res.lt;
         end
         ST_VA: begin
            // Reach B: stay at B, or move from A (tie picks the move)
            alu_op     = '{x: best_a_ff, y: sw_ff, z: best_b_ff};
            nb_in      = alu_res.lt ? best_b_ff : alu_res.sum[BEST_W-1:0];
            bits_in[1] = alu_res.lt;
         end
         ST_SA: begin
            alu_op    = '{x: na_ff, y: ca_ff, z: '0};
            best_a_in = alu_res.sum[BEST_W-1:0];
         end
         ST_SB: begin
            alu_op    = '{x: nb_ff, y: cb_ff, z: '0};
            best_b_in = alu_res.sum[BEST_W-1:0];
            back_we   = 1'b1;
            count_in  = count_ff + CW'(1);
         end
         ST_FIN: begin
            // Pick the final site, tie goes to B; clear costs for the next plan
            alu_op    = '{x: best_b_ff, y: '0, z: best_a_ff};
            cur_in    = ~alu_res.lt;
            plan_we   = 1'b1;
            plan_wa   = last_idx;
            plan_wd   = ~alu_res.lt;
            ptr_in    = last_idx;
            best_a_in = '0;
            best_b_in = '0;
         end
         ST_TB_RD: begin
            back_re = 1'b1;
         end
         ST_TB_WR: begin
            // Step one period back through the backpointer of the held site
            cur_in  = back_rd[cur_ff];
            plan_we = 1'b1;
            plan_wa = ptr_ff - AW'(1);
            plan_wd = back_rd[cur_ff];
            ptr_in  = ptr_ff - AW'(1);
         end
         ST_EM_RD: begin
            plan_re = 1'b1;
         end
         ST_EM_LD: begin
            rsp_valid_in = 1'b1;
            rsp_site_in  = plan_rd;
            rsp_end_in   = (ptr_ff == last_idx);
         end
         ST_EM_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_end_ff) begin
                  count_in = '0;
               end else begin
                  ptr_in = ptr_ff + AW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sw_ff        <= '0;
         best_a_ff    <= '0;
         best_b_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sw_ff        <= sw_in;
         best_a_ff    <= best_a_in;
         best_b_ff    <= best_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: hold until the sequencer loads them
   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      cur_ff      <= cur_in;
      na_ff       <= na_in;
      nb_ff       <= nb_in;
      bits_ff     <= bits_in;
      ca_ff       <= ca_in;
      cb_ff       <= cb_in;
      last_ff     <= last_in;
      rsp_site_ff <= rsp_site_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_site     = rsp_site_ff;
   assign rsp_plan_end = rsp_end_ff;

   `ASSERT_NEVER(a_no_accept_while_emitting, clock, reset,
                 req_ready && rsp_valid_ff,
                 "input taken while a result is pending")
   `ASSERT_NEVER(a_count_in_range, clock, reset,
                 count_ff > CW'(MAX_PERIODS),
                 "period count beyond store depth")
   `ASSERT_PROP(a_plan_end_clears, clock, reset,
                (rsp_valid && rsp_ready && rsp_plan_end) |=> (count_ff == '0),
                "plan not cleared after last result")
   `ASSERT_PROP(a_rsp_from_load, clock, reset,
                $rose(rsp_valid_ff) |-> $past(state_ff == ST_EM_LD),
                "result raised outside load step")

endmodule

/* rtl/tssc_ram.sv */
// Generic memory: one write port and one read port, registered read data.
// Depends on nothing.
module tssc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tssc_alu.sv */
// Shared cost unit of the planner: one add and one less-than compare
// against the sum. Depends on tssc_pkg.
module tssc_alu (
   input  tssc_pkg::alu_op_type  op,
   output tssc_pkg::alu_res_type res
);
   import tssc_pkg::*;

   logic [SUM_W-1:0] sum;

   assign sum     = SUM_W'(op.x) + SUM_W'(op.y);
   assign res.sum = sum;
   assign res.lt  = SUM_W'(op.z) < sum;

endmodule

/* dv/tb_two_state_switch_cost_plan.sv */
// Self-checking testbench for two_state_switch_cost_plan: a period-by-period
// predictor of the two-site cost plan and its traceback checks every result.
// Depends on tssc_pkg and the RTL of the planner; needs no other file.
`timescale 1ns / 100ps

module tb_two_state_switch_cost_plan;

   import tssc_pkg::*;

   localparam int PLAN_DEPTH = MAX_PERIODS_DEF;
   localparam int CLK_HALF   = 4;

   // cost patterns for the random periods
   typedef enum int {
      COST_FULL,
      COST_NEAR,
      COST_EDGE
   } cost_mode_type;

   typedef struct packed {
      logic site;
      logic plan_end;
   } plan_step_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [COST_W-1:0] req_cost_site_a;
   logic [COST_W-1:0] req_cost_site_b;
   logic              req_final_period;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_site;
   logic              rsp_plan_end;
   logic              csr_valid;
   logic              csr_ready;
   logic [COST_W-1:0] csr_switch_cost;

   // predictor state: running best costs, backpointers and the live cost
   logic [COST_W-1:0] move_cost;
   logic [BEST_W-1:0] best_at_a;
   logic [BEST_W-1:0] best_at_b;
   logic [1:0]        came_from [PLAN_DEPTH];
   int unsigned       periods_open;

   plan_step_type     plan_steps_due [$];
   plan_step_type     step_seen;

   int unsigned       periods_sent;
   int unsigned       sites_checked;
   int unsigned       plans_closed;
   int unsigned       cost_writes;
   int unsigned       error_count;

   // sender burst shaping and receiver stall pattern
   bit                req_steady;
   bit                rsp_steady;
   int                burst_left;
   int                ready_run;
   int                ready_hold;

   two_state_switch_cost_plan #(
      .MAX_PERIODS(PLAN_DEPTH)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cost_site_a (req_cost_site_a),
      .req_cost_site_b (req_cost_site_b),
      .req_final_period(req_final_period),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_site        (rsp_site),
      .rsp_plan_end    (rsp_plan_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_switch_cost (csr_switch_cost)
   );

   always #CLK_HALF clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor. Advance the two best costs by one period and, when the
   // plan closes, trace it back and queue one expected site per period.
   // Staying wins only when strictly cheaper, so a tie takes the move;
   // at the close a tie between the final costs picks site B.
   // ------------------------------------------------------------------
   function automatic void plan_period(input logic [COST_W-1:0] cost_a,
                                       input logic [COST_W-1:0] cost_b,
                                       input logic last_period);
      logic [31:0]   reach_a_from_b;
      logic [31:0]   reach_b_from_a;
      logic [31:0]   keep_a;
      logic [31:0]   keep_b;
      logic [1:0]    from_bits;
      logic          trail [PLAN_DEPTH];
      plan_step_type step;
      int            n;

      if (periods_open == 0) begin
         // first period of a plan: load the costs, backpointers never read
         best_at_a = cost_a;
         best_at_b = cost_b;
         came_from[0] = 2'b00;
      end else begin
         reach_a_from_b = 32'(best_at_b) + 32'(move_cost);
         reach_b_from_a = 32'(best_at_a) + 32'(move_cost);
         from_bits = 2'b00;
         if (32'(best_at_a) < reach_a_from_b) begin
            keep_a = 32'(best_at_a);
         end else begin
            keep_a = reach_a_from_b;
            from_bits[0] = 1'b1;
         end
         if (32'(best_at_b) < reach_b_from_a) begin
            keep_b = 32'(best_at_b);
            from_bits[1] = 1'b1;
         end else begin
            keep_b = reach_b_from_a;
         end
         best_at_a = BEST_W'(keep_a + 32'(cost_a));
         best_at_b = BEST_W'(keep_b + 32'(cost_b));
         came_from[periods_open] = from_bits;
      end
      periods_open++;

      if (!last_period && periods_open < PLAN_DEPTH)
         return;

      // close: pick the cheaper end site, then walk the backpointers
      n = periods_open;
      trail[n-1] = (best_at_a < best_at_b) ? 1'b0 : 1'b1;
      for (int i = n - 1; i >= 1; i--)
         trail[i-1] = came_from[i][trail[i]];
      for (int i = 0; i < n; i++) begin
         step.site     = trail[i];
         step.plan_end = (i == n - 1);
         plan_steps_due.push_back(step);
      end
      best_at_a    = '0;
      best_at_b    = '0;
      periods_open = 0;
      plans_closed++;
   endfunction

   // ------------------------------------------------------------------
   // Result checker: compare every accepted result transaction with the
   // oldest expected site, field by field.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (plan_steps_due.size() == 0) begin
            $display("%0t: result with nothing expected: site=%0b plan_end=%0b",
                     $time, rsp_site, rsp_plan_end);
            error_count++;
         end else begin
            step_seen = plan_steps_due.pop_front();
            if (rsp_site !== step_seen.site) begin
               $display("%0t: site mismatch: expected %0b, actual %0b",
                        $time, step_seen.site, rsp_site);
               error_count++;
            end
            if (rsp_plan_end !== step_seen.plan_end) begin
               $display("%0t: plan_end mismatch: expected %0b, actual %0b",
                        $time, step_seen.plan_end, rsp_plan_end);
               error_count++;
            end
            sites_checked++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: runs of ready of random length broken by random stalls;
   // hold ready high throughout while rsp_steady is set.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (rsp_steady) begin
         rsp_ready <= 1'b1;
      end else if (ready_run > 0) begin
         ready_run--;
         rsp_ready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold--;
         rsp_ready <= 1'b0;
      end else begin
         ready_run  = $urandom_range(0, 10);
         ready_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                  : $urandom_range(1, 5);
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers. Every task is entered and left at a falling edge.
   // ------------------------------------------------------------------

   // Drive one period, wait for its transaction, then, unless req_steady is set,
   // open a gap between bursts when the current burst is used up.
   task automatic send_period(input logic [COST_W-1:0] cost_a,
                              input logic [COST_W-1:0] cost_b,
                              input logic last_period);
      int gap;

      req_valid        <= 1'b1;
      req_cost_site_a  <= cost_a;
      req_cost_site_b  <= cost_b;
      req_final_period <= last_period;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      plan_period(cost_a, cost_b, last_period);
      periods_sent++;
      @(negedge clock);
      if (!req_steady) begin
         if (burst_left <= 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                              : $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
            burst_left = $urandom_range(0, 8);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Drop the request, let every expected site drain, then allow for a
   // period still in the cost unit before anything touches the register.
   task automatic drain_plans();
      req_valid <= 1'b0;
      while (plan_steps_due.size() != 0)
         @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_switch_cost(input logic [COST_W-1:0] value);
      csr_valid       <= 1'b1;
      csr_switch_cost <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      move_cost = value;
      cost_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [COST_W-1:0] pick_cost(input cost_mode_type mode);
      int unsigned spread;

      case (mode)
         COST_NEAR: begin
            // keep costs within reach of the move cost so switches compete
            spread = 32'(move_cost) * 2 + 16;
            if (spread > 65535)
               spread = 65535;
            return COST_W'($urandom_range(0, spread));
         end
         COST_EDGE: begin
            return $urandom_range(0, 1) ? '1 : '0;
         end
         default: begin
            return COST_W'($urandom);
         end
      endcase
   endfunction

   // Send one complete plan. A plan of the full store depth closes by itself,
   // so its final flag is random; any shorter plan ends on a flagged period.
   task automatic send_plan(input int periods, input cost_mode_type mode);
      logic last_period;

      for (int p = 0; p < periods; p++) begin
         if (p == periods - 1)
            last_period = (periods == PLAN_DEPTH) ? 1'($urandom_range(0, 1)) : 1'b1;
         else
            last_period = 1'b0;
         send_period(pick_cost(mode), pick_cost(mode), last_period);
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Single-period plans at the reset move cost: extremes and the final tie.
   task automatic test_single_periods();
      req_steady = 1'b1;
      rsp_steady = 1'b1;
      send_period('0, '0, 1'b1);
      send_period('0, '1, 1'b1);
      send_period('1, '0, 1'b1);
      send_period('1, '1, 1'b1);
      send_period(16'h0001, 16'h0000, 1'b1);
      drain_plans();
   endtask

   // Move versus stay decisions, the tie that takes the move, the largest
   // move cost and the largest costs.
   task automatic test_switch_rules();
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      // free moves: the path follows the cheaper site every period
      send_period(16'd10, 16'd20, 1'b0);
      send_period(16'd20, 16'd10, 1'b1);
      // all ties: every backpointer takes the move
      send_period(16'd5, 16'd5, 1'b0);
      send_period(16'd1, 16'd1, 1'b0);
      send_period(16'd0, 16'd0, 1'b1);
      drain_plans();

      write_switch_cost('1);
      send_period('0, '1, 1'b0);
      send_period('1, '0, 1'b0);
      send_period('0, '1, 1'b1);
      send_period('1, '1, 1'b0);
      send_period('1, '1, 1'b0);
      send_period('1, '1, 1'b1);
      drain_plans();

      // staying at A costs exactly what arriving from B costs
      write_switch_cost(16'd100);
      send_period(16'd100, 16'd0, 1'b0);
      send_period(16'd50, 16'd50, 1'b0);
      send_period(16'd0, 16'd200, 1'b1);
      drain_plans();
   endtask

   // Plans that fill the period store, closing with and without the flag.
   task automatic test_store_full();
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      write_switch_cost(COST_W'($urandom_range(1, 400)));
      for (int p = 0; p < PLAN_DEPTH; p++)
         send_period(pick_cost(COST_NEAR), pick_cost(COST_NEAR), 1'b0);
      for (int p = 0; p < PLAN_DEPTH; p++)
         send_period(pick_cost(COST_NEAR), pick_cost(COST_NEAR), p == PLAN_DEPTH - 1);
      drain_plans();
   endtask

   // Random plans over a run of move costs; mostly short plans, a few at
   // full depth, with idle stretches and steady stretches on both sides.
   task automatic test_random_plans();
      logic [COST_W-1:0] cost_steps [5];
      int                budget;
      int                periods;
      int                pick;

      cost_steps[0] = '0;
      cost_steps[1] = '1;
      cost_steps[2] = 16'd1;
      cost_steps[3] = COST_W'($urandom_range(2, 300));
      cost_steps[4] = COST_W'($urandom);
      for (int s = 0; s < 5; s++) begin
         write_switch_cost(cost_steps[s]);
         req_steady = (s == 2);
         rsp_steady = (s == 3);
         budget = 45;
         while (budget > 0) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
               periods = PLAN_DEPTH;
            else if (pick < 4)
               periods = $urandom_range(9, 24);
            else
               periods = $urandom_range(1, 8);
            pick = $urandom_range(0, 9);
            send_plan(periods, (pick < 6) ? COST_NEAR : (pick < 9) ? COST_FULL : COST_EDGE);
            budget -= periods;
         end
         drain_plans();
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_cost_site_a  = '0;
      req_cost_site_b  = '0;
      req_final_period = 1'b0;
      rsp_ready        = 1'b0;
      csr_valid        = 1'b0;
      csr_switch_cost  = '0;
      move_cost        = '0;
      best_at_a        = '0;
      best_at_b        = '0;
      periods_open     = 0;
      periods_sent     = 0;
      sites_checked    = 0;
      plans_closed     = 0;
      cost_writes      = 0;
      error_count      = 0;
      req_steady       = 1'b1;
      rsp_steady       = 1'b1;
      burst_left       = 0;
      ready_run        = 0;
      ready_hold       = 0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_single_periods();
      test_switch_rules();
      test_store_full();
      test_random_plans();

      $display("Covered %0d periods in %0d plans, %0d sites checked, %0d move cost writes",
               periods_sent, plans_closed, sites_checked, cost_writes);
      $display("Move costs included zero and full scale; plans ran from one period to full depth");
      if (error_count == 0) begin
         $display("two_state_switch_cost_plan test passed");
      end else begin
         $display("two_state_switch_cost_plan test failed");
      end
      $finish;
   end

   // Watchdog: end a hung run long after the slowest correct one.
   initial begin
      #4_000_000;
      $display("two_state_switch_cost_plan test failed");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/tssc_pkg.sv
rtl/tssc_ram.sv
rtl/tssc_alu.sv
rtl/two_state_switch_cost_plan.sv
dv/tb_two_state_switch_cost_plan.sv
